// ----- sv/half_single_float_byte_converter_core_macros.svh -----
// assertion macros for the converter checker
`ifndef HALF_SINGLE_FLOAT_BYTE_CONVERTER_CORE_MACROS_SVH
`define HALF_SINGLE_FLOAT_BYTE_CONVERTER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define HSFB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every clock edge, reset included
`define HSFB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/hsfb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsfb_pkg
// Shared codes, constants and types for the half/single float byte converter.
// ----------------------------------------------------------------------------
package hsfb_pkg;

  localparam logic [1:0] REQ_DEC_F32 = 2'd0;
  localparam logic [1:0] REQ_ENC_F32 = 2'd1;
  localparam logic [1:0] REQ_DEC_F16 = 2'd2;
  localparam logic [1:0] REQ_ENC_F16 = 2'd3;

  localparam logic [2:0] CNT_NONE = 3'd0;
  localparam logic [2:0] CNT_F16  = 3'd2;
  localparam logic [2:0] CNT_F32  = 3'd4;

  localparam logic [4:0] HALF_EXP_MAX = 5'h1F;
  localparam logic [7:0] F32_EXP_MAX  = 8'hFF;
  // half exponent of 1 rebiased to single
  localparam logic [7:0] SUB_EXP_BASE = 8'd113;
  localparam logic [7:0] EXP_REBIAS   = 8'd112;

  // stage 1 to stage 2 bundle
  typedef struct packed {
    logic [1:0]  req;
    logic        sign;
    logic [4:0]  hexp;
    logic [9:0]  hman;
    logic [31:0] word;
  } s1_t;

  // stage 2 to stage 3 bundle
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] res;
  } s2_t;

endpackage

// ----- sv/half_single_float_byte_converter_core.sv -----
// Throughput: one beat per cycle unless the output stalls; three register
// stages, each with valid bit. A stall on the output holds stage 3, and a
// full stage waits only while the next one is held; empty stages refill.
// Reset clears all stage valid bits and big_endian to 0.
// ----------------------------------------------------------------------------
// half_single_float_byte_converter_core
// Byte order and binary16/binary32 conversion, three stage pipeline.
// ----------------------------------------------------------------------------
module half_single_float_byte_converter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] data_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] data_out_o,
  output logic [2:0]  byte_count_o
);

  logic big_endian_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  hsfb_pkg::s1_t s1_d, s1_q;
  hsfb_pkg::s2_t s2_d, s2_q;
  logic [31:0] res3_d, res3_q;
  logic [2:0]  cnt3_d, cnt3_q;

  // stage enables: a stage loads when it is empty or moves on
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      big_endian_q <= cfg_wdata_i;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: input byte order, split half fields
  always_comb begin
    logic [31:0] w;
    logic [15:0] h;
    w = big_endian_q ? {data_in_i[7:0], data_in_i[15:8], data_in_i[23:16],
                        data_in_i[31:24]} : data_in_i;
    h = big_endian_q ? {data_in_i[7:0], data_in_i[15:8]} : data_in_i[15:0];
    s1_d.req  = req_type_i;
    s1_d.word = (req_type_i == hsfb_pkg::REQ_ENC_F16) ? data_in_i : w;
    s1_d.sign = h[15];
    s1_d.hexp = h[14:10];
    s1_d.hman = h[9:0];
  end

  // stage 2: conversions
  always_comb begin
    logic [9:0]  m;
    logic [3:0]  lz;
    logic [7:0]  e;
    logic [15:0] hr;
    logic [8:0]  fe;
    m  = s1_q.hman;
    lz = 4'd0;
    e  = 8'd0;
    hr = 16'd0;
    fe = {1'b0, s1_q.word[30:23]};
    for (int i = 0; i < 10; i++) begin
      if (m[9 - i] && lz == 4'd0 && (m >> (10 - i)) == 10'd0) lz = 4'(i + 1);
    end
    s2_d.req = s1_q.req;
    s2_d.res = s1_q.word;
    if (s1_q.req == hsfb_pkg::REQ_DEC_F16) begin
      if (s1_q.hexp == 5'd0) begin
        if (m == 10'd0) begin
          s2_d.res = {s1_q.sign, 31'd0};
        end else begin
          e = hsfb_pkg::SUB_EXP_BASE - 8'(lz);
          s2_d.res = {s1_q.sign, e, 10'(m << lz), 13'd0};
        end
      end else if (s1_q.hexp == hsfb_pkg::HALF_EXP_MAX) begin
        s2_d.res = {s1_q.sign, hsfb_pkg::F32_EXP_MAX, m, 13'd0};
      end else begin
        s2_d.res = {s1_q.sign, 8'(s1_q.hexp) + hsfb_pkg::EXP_REBIAS, m, 13'd0};
      end
    end else if (s1_q.req == hsfb_pkg::REQ_ENC_F16) begin
      if (fe <= 9'(hsfb_pkg::EXP_REBIAS)) begin
        hr = {s1_q.word[31], 15'd0};
      end else if (fe >= 9'(hsfb_pkg::EXP_REBIAS) + 9'(hsfb_pkg::HALF_EXP_MAX)) begin
        hr = {s1_q.word[31], hsfb_pkg::HALF_EXP_MAX, 10'd0};
      end else begin
        hr = {s1_q.word[31], 5'(fe - 9'(hsfb_pkg::EXP_REBIAS)), s1_q.word[22:13]};
      end
      s2_d.res = {16'd0, hr};
    end
  end

  // stage 3: output byte order of half results, and byte count
  always_comb begin
    res3_d = s2_q.res;
    cnt3_d = hsfb_pkg::CNT_NONE;
    case (s2_q.req)
      hsfb_pkg::REQ_ENC_F32: cnt3_d = hsfb_pkg::CNT_F32;
      hsfb_pkg::REQ_ENC_F16: begin
        cnt3_d = hsfb_pkg::CNT_F16;
        if (big_endian_q) res3_d = {16'd0, s2_q.res[7:0], s2_q.res[15:8]};
      end
      default: cnt3_d = hsfb_pkg::CNT_NONE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) begin
      res3_q <= res3_d;
      cnt3_q <= cnt3_d;
    end
  end

  assign out_valid_o  = v3_q;
  assign data_out_o   = res3_q;
  assign byte_count_o = cnt3_q;

endmodule

// ----- sv/hsfb_checker.sv -----
// ----------------------------------------------------------------------------
// hsfb_checker
// Port level checks for the converter, bound to the converter core module.
// ----------------------------------------------------------------------------
`include "half_single_float_byte_converter_core_macros.svh"

module hsfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] data_out_o,
  input logic [2:0]  byte_count_o
);

  logic out_held;
  logic cnt_legal;
  logic half_beat;

  assign out_held  = out_valid_o && out_stall_i;
  assign cnt_legal = byte_count_o == hsfb_pkg::CNT_NONE ||
                     byte_count_o == hsfb_pkg::CNT_F16 ||
                     byte_count_o == hsfb_pkg::CNT_F32;
  assign half_beat = out_valid_o && byte_count_o == hsfb_pkg::CNT_F16;

  // in reset the output beat is not valid
  `HSFB_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_valid_o, "valid in reset")
  // stalled output beat holds
  `HSFB_ASSERT(a_hold, clk_i, rst_ni, out_held |=> out_valid_o && $stable(data_out_o) && $stable(byte_count_o), "beat changed")
  // byte count is one of the legal counts
  `HSFB_ASSERT(a_cnt, clk_i, rst_ni, out_valid_o |-> cnt_legal, "bad byte count")
  // half encode leaves upper bytes clear
  `HSFB_ASSERT(a_half_hi, clk_i, rst_ni, half_beat |-> data_out_o[31:16] == 16'd0, "upper half set")
  // input only stalls when the output does
  `HSFB_ASSERT(a_stall, clk_i, rst_ni, in_stall_o |-> out_held, "spurious stall")

endmodule

bind half_single_float_byte_converter_core hsfb_checker u_hsfb_checker (.*);
